/* hdl/hwrdp_pkg.sv */
// ----------------------------------------------------------------------------
// hwrdp_pkg
// Types, constants and binary16/binary32 arithmetic for the row dot product.
// ----------------------------------------------------------------------------
`default_nettype none

package hwrdp_pkg;

    localparam int LANES   = 16;
    localparam int LANE_W  = 4;
    localparam int COUNT_W = 16;
    localparam int ROW_W   = 16;
    localparam int HALF_W  = 16;
    localparam int SGL_W   = 32;

    localparam logic [SGL_W-1:0] CANON_NAN = 32'h7FC0_0000;

    typedef struct packed {
        logic [ROW_W-1:0]  row;
        logic [LANE_W-1:0] lane;
        logic              lane_item;
        logic              lane_last;
        logic              close;
    } t_tag;

    typedef struct packed {
        logic              sign;
        logic              nan;
        logic              inf;
        logic              zero;
        logic signed [9:0] expo;
        logic [23:0]       mant;
    } t_mop;

    typedef struct packed {
        logic               sign;
        logic               nan;
        logic               inf;
        logic               zero;
        logic signed [10:0] expo;
        logic [47:0]        prod;
    } t_mprod;

    typedef enum logic [2:0] {
        RED_IDLE,
        RED_L1,
        RED_L2,
        RED_L3,
        RED_L4
    } t_red_state;

    function automatic logic [SGL_W-1:0] half_to_single(input logic [HALF_W-1:0] h);
        logic       s;
        logic [4:0] ex;
        logic [9:0] man;
        logic [3:0] pos;
        logic [9:0] frac;
        logic [7:0] e;
        s    = h[15];
        ex   = h[14:10];
        man  = h[9:0];
        pos  = '0;
        for (int i = 0; i < 10; i++) begin
            if (man[i]) begin
                pos = 4'(i);
            end
        end
        frac = 10'(man << (4'd10 - pos));
        e    = 8'd103 + {4'b0, pos};
        if (ex == 5'h1F) begin
            return {s, 8'hFF, man, 13'b0};
        end else if (ex == 5'h00) begin
            if (man == '0) begin
                return {s, 31'b0};
            end
            return {s, e, frac, 13'b0};
        end
        return {s, 8'(ex) + 8'd112, man, 13'b0};
    endfunction

    function automatic t_mop mul_unpack(input logic [SGL_W-1:0] a);
        t_mop        r;
        logic [7:0]  e;
        logic [22:0] f;
        logic [23:0] m;
        logic [4:0]  lz;
        e  = a[30:23];
        f  = a[22:0];
        m  = {1'b0, f};
        lz = 5'd23;
        for (int i = 0; i < 24; i++) begin
            if (m[i]) begin
                lz = 5'(23 - i);
            end
        end
        r.sign = a[31];
        r.nan  = (e == 8'hFF) && (f != '0);
        r.inf  = (e == 8'hFF) && (f == '0);
        r.zero = (e == 8'h00) && (f == '0);
        if (e == 8'h00) begin
            r.mant = m << lz;
            r.expo = 10'sd1 - signed'({5'b0, lz});
        end else begin
            r.mant = {1'b1, f};
            r.expo = signed'({2'b0, e});
        end
        return r;
    endfunction

    function automatic t_mprod mul_core(input t_mop a, input t_mop b);
        t_mprod r;
        r.sign = a.sign ^ b.sign;
        r.nan  = a.nan | b.nan | (a.inf & b.zero) | (a.zero & b.inf);
        r.inf  = a.inf | b.inf;
        r.zero = a.zero | b.zero;
        r.prod = {24'b0, a.mant} * {24'b0, b.mant};
        r.expo = signed'({a.expo[9], a.expo}) + signed'({b.expo[9], b.expo}) - 11'sd127;
        return r;
    endfunction

    function automatic logic [SGL_W-1:0] mul_round(input t_mprod m);
        logic signed [10:0] erp;
        logic signed [10:0] d;
        logic [47:0]        q;
        logic [47:0]        sh_q;
        logic [5:0]         sh;
        logic [7:0]         ef;
        logic [23:0]        t;
        logic               g;
        logic               st;
        logic               inc;
        logic [30:0]        packed_v;
        erp = m.expo + signed'({10'b0, m.prod[47]});
        q   = m.prod[47] ? m.prod : (m.prod << 1);
        d   = 11'sd1 - erp;
        if (erp >= 11'sd1) begin
            sh = '0;
            ef = erp[7:0];
        end else begin
            sh = (d > 11'sd48) ? 6'd48 : d[5:0];
            ef = '0;
        end
        sh_q     = q >> sh;
        t        = sh_q[47:24];
        g        = sh_q[23];
        st       = (|sh_q[22:0]) | ((sh_q << sh) != q);
        inc      = g & (st | t[0]);
        packed_v = {ef, t[22:0]} + {30'b0, inc};
        if (m.nan) begin
            return CANON_NAN;
        end else if (m.inf || erp > 11'sd254) begin
            return {m.sign, 8'hFF, 23'b0};
        end else if (m.zero) begin
            return {m.sign, 31'b0};
        end
        return {m.sign, packed_v};
    endfunction

    function automatic logic [SGL_W-1:0] fp_add(input logic [SGL_W-1:0] a,
                                                input logic [SGL_W-1:0] b);
        logic [SGL_W-1:0] x;
        logic [SGL_W-1:0] y;
        logic             nan_a;
        logic             nan_b;
        logic             inf_a;
        logic             inf_b;
        logic [7:0]       xe;
        logic [7:0]       ye;
        logic [7:0]       d;
        logic [4:0]       sh;
        logic [26:0]      mx;
        logic [26:0]      my;
        logic [26:0]      my_sh;
        logic [26:0]      my_al;
        logic [27:0]      s;
        logic [26:0]      n;
        logic [4:0]       lz;
        logic [7:0]       maxsh;
        logic [7:0]       shl;
        logic [8:0]       e9;
        logic [23:0]      t;
        logic [7:0]       ef;
        logic             inc;
        logic [30:0]      packed_v;
        nan_a = (a[30:23] == 8'hFF) && (a[22:0] != '0);
        nan_b = (b[30:23] == 8'hFF) && (b[22:0] != '0);
        inf_a = (a[30:23] == 8'hFF) && (a[22:0] == '0);
        inf_b = (b[30:23] == 8'hFF) && (b[22:0] == '0);
        if (a[30:0] < b[30:0]) begin
            x = b;
            y = a;
        end else begin
            x = a;
            y = b;
        end
        xe    = (x[30:23] == '0) ? 8'd1 : x[30:23];
        ye    = (y[30:23] == '0) ? 8'd1 : y[30:23];
        d     = xe - ye;
        sh    = (d > 8'd27) ? 5'd27 : d[4:0];
        mx    = {(x[30:23] != '0), x[22:0], 3'b0};
        my    = {(y[30:23] != '0), y[22:0], 3'b0};
        my_sh = my >> sh;
        my_al = my_sh | {26'b0, ((my_sh << sh) != my)};
        if (x[31] == y[31]) begin
            s = {1'b0, mx} + {1'b0, my_al};
        end else begin
            s = {1'b0, mx} - {1'b0, my_al};
        end
        lz = 5'd27;
        for (int i = 0; i < 27; i++) begin
            if (s[i]) begin
                lz = 5'(26 - i);
            end
        end
        maxsh = xe - 8'd1;
        shl   = ({3'b0, lz} < maxsh) ? {3'b0, lz} : maxsh;
        if (s[27]) begin
            n  = {s[27:2], s[1] | s[0]};
            e9 = {1'b0, xe} + 9'd1;
        end else begin
            n  = s[26:0] << shl;
            e9 = {1'b0, xe} - {1'b0, shl};
        end
        t        = n[26:3];
        ef       = t[23] ? e9[7:0] : 8'd0;
        inc      = n[2] & (n[1] | n[0] | t[0]);
        packed_v = {ef, t[22:0]} + {30'b0, inc};
        if (nan_a || nan_b || (inf_a && inf_b && (a[31] != b[31]))) begin
            return CANON_NAN;
        end else if (inf_a) begin
            return {a[31], 8'hFF, 23'b0};
        end else if (inf_b) begin
            return {b[31], 8'hFF, 23'b0};
        end else if (s == '0) begin
            return {x[31] & y[31], 31'b0};
        end else if (e9 == 9'd255) begin
            return {x[31], 8'hFF, 23'b0};
        end
        return {x[31], packed_v};
    endfunction

endpackage

`default_nettype wire

/* hdl/hwrdp_mul.sv */
// ----------------------------------------------------------------------------
// hwrdp_mul
// Four-stage product pipeline: capture, unpack, multiply, round to binary32.
// ----------------------------------------------------------------------------
`default_nettype none

module hwrdp_mul (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    output logic                           o_ready,
    input  wire logic [hwrdp_pkg::HALF_W-1:0] i_weight,
    input  wire logic [hwrdp_pkg::SGL_W-1:0]  i_act,
    input  wire hwrdp_pkg::t_tag           i_tag,
    output logic                           o_valid,
    input  wire logic                      i_take,
    output logic [hwrdp_pkg::SGL_W-1:0]    o_prod,
    output hwrdp_pkg::t_tag                o_tag
);
    import hwrdp_pkg::*;

    logic             r_v1, r_v2, r_v3, r_v4;
    logic             s_e1, s_e2, s_e3, s_e4;
    logic [HALF_W-1:0] r_w1;
    logic [SGL_W-1:0] r_x1;
    t_tag             r_tag1, r_tag2, r_tag3, r_tag4;
    t_mop             r_opa, r_opb;
    t_mop             n_opa, n_opb;
    t_mprod           r_mp;
    t_mprod           n_mp;
    logic [SGL_W-1:0] r_p;
    logic [SGL_W-1:0] n_p;

    assign s_e4    = !r_v4 || i_take;
    assign s_e3    = !r_v3 || s_e4;
    assign s_e2    = !r_v2 || s_e3;
    assign s_e1    = !r_v1 || s_e2;
    assign o_ready = s_e1;
    assign o_valid = r_v4;
    assign o_prod  = r_p;
    assign o_tag   = r_tag4;

    always_comb begin
        n_opa = mul_unpack(half_to_single(r_w1));
        n_opb = mul_unpack(r_x1);
        n_mp  = mul_core(r_opa, r_opb);
        n_p   = mul_round(r_mp);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (s_e1) r_v1 <= i_valid;
            if (s_e2) r_v2 <= r_v1;
            if (s_e3) r_v3 <= r_v2;
            if (s_e4) r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_e1) begin
            r_w1   <= i_weight;
            r_x1   <= i_act;
            r_tag1 <= i_tag;
        end
        if (s_e2) begin
            r_opa  <= n_opa;
            r_opb  <= n_opb;
            r_tag2 <= r_tag1;
        end
        if (s_e3) begin
            r_mp   <= n_mp;
            r_tag3 <= r_tag2;
        end
        if (s_e4) begin
            r_p    <= n_p;
            r_tag4 <= r_tag3;
        end
    end

endmodule

`default_nettype wire

/* hdl/hwrdp_acc.sv */
// ----------------------------------------------------------------------------
// hwrdp_acc
// Lane and tail accumulation, lane reduction sequencer and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module hwrdp_acc (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_clr,
    input  wire logic                     i_valid,
    input  wire logic [hwrdp_pkg::SGL_W-1:0] i_prod,
    input  wire hwrdp_pkg::t_tag          i_tag,
    output logic                          o_take,
    output logic                          o_valid,
    input  wire logic                     i_ready,
    output logic [hwrdp_pkg::SGL_W-1:0]   o_sum,
    output logic [hwrdp_pkg::ROW_W-1:0]   o_row
);
    import hwrdp_pkg::*;

    t_red_state       r_state, n_state;
    logic [SGL_W-1:0] r_lane [LANES];
    logic [SGL_W-1:0] r_tail;
    logic [SGL_W-1:0] r_red [8];
    logic             r_red_close;
    logic [ROW_W-1:0] r_red_row;
    logic             r_ovalid;
    logic [SGL_W-1:0] r_osum;
    logic [ROW_W-1:0] r_orow;

    logic             s_busy;
    logic             s_out_free;
    logic             s_fire;
    logic             s_red_done;
    logic             s_tail_out;
    logic             s_out_load;
    logic [SGL_W-1:0] s_acc_a;
    logic [SGL_W-1:0] s_acc_y;
    logic [SGL_W-1:0] s_red_a [8];
    logic [SGL_W-1:0] s_red_b [8];
    logic [SGL_W-1:0] s_red_y [8];

    assign s_out_free = !r_ovalid || i_ready;
    assign s_tail_out = i_tag.close && !i_tag.lane_item;
    assign s_fire     = i_valid && !s_busy && (!s_tail_out || s_out_free);
    assign s_out_load = (s_fire && s_tail_out) || (s_red_done && r_red_close);
    assign s_acc_a    = i_tag.lane_item ? r_lane[i_tag.lane] : r_tail;
    assign s_acc_y    = fp_add(s_acc_a, i_prod);
    assign o_take     = s_fire;
    assign o_valid    = r_ovalid;
    assign o_sum      = r_osum;
    assign o_row      = r_orow;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            RED_IDLE: if (s_fire && i_tag.lane_last) n_state = RED_L1;
            RED_L1:   n_state = RED_L2;
            RED_L2:   n_state = RED_L3;
            RED_L3:   n_state = RED_L4;
            RED_L4:   if (!r_red_close || s_out_free) n_state = RED_IDLE;
            default:  n_state = RED_IDLE;
        endcase
    end

    always_comb begin
        s_busy     = (r_state != RED_IDLE);
        s_red_done = (r_state == RED_L4) && (!r_red_close || s_out_free);
        for (int j = 0; j < 8; j++) begin
            if (r_state == RED_L1) begin
                s_red_a[j] = r_lane[(j / 2) + (j % 2) * 8];
                s_red_b[j] = r_lane[(j / 2) + (j % 2) * 8 + 4];
            end else if (j < 4) begin
                s_red_a[j] = r_red[2 * j];
                s_red_b[j] = r_red[2 * j + 1];
            end else begin
                s_red_a[j] = '0;
                s_red_b[j] = '0;
            end
            s_red_y[j] = fp_add(s_red_a[j], s_red_b[j]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clr) begin
            r_state     <= RED_IDLE;
            r_red_close <= 1'b0;
            r_tail      <= '0;
            for (int i = 0; i < LANES; i++) begin
                r_lane[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (r_state == RED_L1) begin
                for (int i = 0; i < LANES; i++) begin
                    r_lane[i] <= '0;
                end
            end else if (s_fire && i_tag.lane_item) begin
                r_lane[i_tag.lane] <= s_acc_y;
            end
            if (s_fire && i_tag.lane_last) begin
                r_red_close <= i_tag.close;
            end
            if (s_fire && !i_tag.lane_item) begin
                r_tail <= i_tag.close ? '0 : s_acc_y;
            end else if (s_red_done && !r_red_close) begin
                r_tail <= s_red_y[0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (s_out_load) begin
            r_ovalid <= 1'b1;
        end else if (i_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_fire && i_tag.lane_last) begin
            r_red_row <= i_tag.row;
        end
        unique case (r_state)
            RED_L1: begin
                for (int j = 0; j < 8; j++) begin
                    r_red[j] <= s_red_y[j];
                end
            end
            RED_L2: begin
                r_red[0] <= s_red_y[0];
                r_red[1] <= s_red_y[2];
                r_red[2] <= s_red_y[1];
                r_red[3] <= s_red_y[3];
            end
            RED_L3: begin
                r_red[0] <= s_red_y[0];
                r_red[1] <= s_red_y[1];
            end
            default: begin
            end
        endcase
        if (s_out_load) begin
            r_osum <= s_busy ? s_red_y[0] : s_acc_y;
            r_orow <= s_busy ? r_red_row : i_tag.row;
        end
    end

endmodule

`default_nettype wire

/* hdl/half_weight_row_dot_product_core.sv */
// ----------------------------------------------------------------------------
// half_weight_row_dot_product_core
// Dot products of binary16 weight rows with a binary32 vector, one per row.
// ----------------------------------------------------------------------------
//  Channel  Ports                              Content
//  s        i_s_tvalid o_s_tready i_s_tdata    one column: weight, activation, row
//  m        o_m_tvalid i_m_tready o_m_tdata    one row: binary32 sum, row number
//  cfg      i_cfg_valid o_cfg_ready i_cfg_data column count
//
// One column transfer is taken per cycle while the product pipeline is not
// stalled. A row that ends in tail columns gives its result through the four
// product stages and the accumulate stage; one that ends on a full block also
// passes the lane reduction states L1 to L4, during which intake stops.
// Reset is synchronous and leaves the column count at sixteen. A stalled
// result register lets the product pipeline fill before intake stops.
// ----------------------------------------------------------------------------
`default_nettype none

module half_weight_row_dot_product_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    // [15:0] weight_half, [47:16] activation, [63:48] row_number
    input  wire logic [63:0] i_s_tdata,
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    // [31:0] row_sum, [47:32] out_row
    output logic [47:0]      o_m_tdata,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [15:0] i_cfg_data
);
    import hwrdp_pkg::*;

    logic [COUNT_W-1:0] r_count;
    logic [COUNT_W-1:0] r_pos;
    logic [COUNT_W-1:0] s_cnt;
    logic [COUNT_W-1:0] s_full;
    logic [COUNT_W:0]   s_pos_inc;
    logic               s_cfg_wr;
    logic               s_accept;
    logic               s_take;
    logic               s_mvalid;
    logic [SGL_W-1:0]   s_prod;
    logic [SGL_W-1:0]   s_sum;
    logic [ROW_W-1:0]   s_row;
    t_tag               s_tag;
    t_tag               s_mtag;

    assign o_cfg_ready = 1'b1;
    assign s_cfg_wr    = i_cfg_valid && o_cfg_ready;
    assign s_accept    = i_s_tvalid && o_s_tready;
    assign s_cnt       = (r_count == '0) ? COUNT_W'(1) : r_count;
    assign s_full      = s_cnt & ~COUNT_W'(LANES - 1);
    assign s_pos_inc   = {1'b0, r_pos} + (COUNT_W+1)'(1);

    always_comb begin
        s_tag.row       = i_s_tdata[63:48];
        s_tag.lane      = r_pos[LANE_W-1:0];
        s_tag.lane_item = r_pos < s_full;
        s_tag.lane_last = (s_full != '0) && (s_pos_inc == {1'b0, s_full});
        s_tag.close     = s_pos_inc == {1'b0, s_cnt};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= COUNT_W'(LANES);
            r_pos   <= '0;
        end else if (s_cfg_wr) begin
            r_count <= i_cfg_data;
            r_pos   <= '0;
        end else if (s_accept) begin
            r_pos <= s_tag.close ? '0 : s_pos_inc[COUNT_W-1:0];
        end
    end

    hwrdp_mul u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_tvalid),
        .o_ready  (o_s_tready),
        .i_weight (i_s_tdata[15:0]),
        .i_act    (i_s_tdata[47:16]),
        .i_tag    (s_tag),
        .o_valid  (s_mvalid),
        .i_take   (s_take),
        .o_prod   (s_prod),
        .o_tag    (s_mtag)
    );

    hwrdp_acc u_acc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clr   (s_cfg_wr),
        .i_valid (s_mvalid),
        .i_prod  (s_prod),
        .i_tag   (s_mtag),
        .o_take  (s_take),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_sum   (s_sum),
        .o_row   (s_row)
    );

    assign o_m_tdata = {s_row, s_sum};

endmodule

`default_nettype wire

/* sim/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for half_weight_row_dot_product_core. Column transfers
// go through a bit-exact binary16/binary32 predictor of the row dot product,
// and each row sum is compared field by field in arrival order. Random rows
// open the run, then a short directed table, then rows under each column count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

    import hwrdp_pkg::*;

    typedef struct {
        logic [31:0] sum;
        logic [15:0] row;
    } t_row_result;

    typedef struct {
        logic [15:0] w;
        logic [31:0] a;
        logic [15:0] r;
        bit          known;
        logic [31:0] sum;
    } t_dir_row;

    localparam logic [31:0] QNAN = 32'h7FC0_0000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [63:0] i_s_tdata;
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [47:0] o_m_tdata;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_data;

    t_row_result row_sums_due[$];
    int          fail_cnt;
    int          src_idle_pct;
    int          snk_idle_pct;
    logic        hold_start;
    bit          hold_taken;
    int          hold_cnt;

    logic [15:0] cols_per_row;
    logic [15:0] col_pos;
    logic [31:0] lane_acc [16];
    logic [31:0] tail_acc;

    half_weight_row_dot_product_core u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #30_000_000;
        $display("FAIL half_weight_row_dot_product_core");
        $finish;
    end

    function automatic logic [31:0] widen_half(input logic [15:0] h);
        logic [9:0] m;
        int         e;
        m = h[9:0];
        if (h[14:10] == 5'h1F) begin
            return {h[15], 8'hFF, m, 13'b0};
        end
        if (h[14:10] != 5'h00) begin
            return {h[15], 8'(h[14:10] + 8'd112), m, 13'b0};
        end
        if (m == '0) begin
            return {h[15], 31'b0};
        end
        e = 113;
        while (!m[9]) begin
            m = m << 1;
            e--;
        end
        return {h[15], 8'(e - 1), m[8:0], 14'b0};
    endfunction

    // Rounds sign * mag * 2**e2 to binary32, nearest even; mag is nonzero.
    function automatic logic [31:0] round_single(input bit sgn, input logic [79:0] mag,
                                                 input int e2);
        int          p;
        int          be;
        int          sh;
        logic [79:0] mant;
        bit          g;
        bit          st;
        longint      bits;
        p = 0;
        for (int i = 0; i < 80; i++) begin
            if (mag[i]) p = i;
        end
        be = p + e2 + 127;
        sh = p - 23;
        if (be < 1) begin
            sh = sh + 1 - be;
            be = 1;
        end
        if (sh <= 0) begin
            mant = mag << (-sh);
        end else if (sh > 80) begin
            mant = '0;
        end else begin
            mant = mag >> sh;
            g    = mag[sh-1];
            st   = (mag & ((80'd1 << (sh - 1)) - 80'd1)) != '0;
            if (g && (st || mant[0])) mant = mant + 80'd1;
        end
        bits = (longint'(be - 1) << 23) + longint'(mant[63:0]);
        if (bits >= 64'h7F80_0000) begin
            return {sgn, 8'hFF, 23'b0};
        end
        return {sgn, bits[30:0]};
    endfunction

    function automatic bit is_nan(input logic [31:0] f);
        return f[30:23] == 8'hFF && f[22:0] != '0;
    endfunction

    function automatic bit is_inf(input logic [31:0] f);
        return f[30:23] == 8'hFF && f[22:0] == '0;
    endfunction

    function automatic logic [31:0] single_mul(input logic [31:0] a, input logic [31:0] b);
        bit         s;
        logic [47:0] ma;
        logic [47:0] mb;
        int         ea;
        int         eb;
        s = a[31] ^ b[31];
        if (is_nan(a) || is_nan(b) || (is_inf(a) && b[30:0] == '0)
            || (a[30:0] == '0 && is_inf(b))) begin
            return QNAN;
        end
        if (is_inf(a) || is_inf(b)) return {s, 8'hFF, 23'b0};
        if (a[30:0] == '0 || b[30:0] == '0) return {s, 31'b0};
        ma = {24'b0, a[30:23] != '0, a[22:0]};
        mb = {24'b0, b[30:23] != '0, b[22:0]};
        ea = (a[30:23] == '0) ? 1 : int'(a[30:23]);
        eb = (b[30:23] == '0) ? 1 : int'(b[30:23]);
        return round_single(s, 80'(ma * mb), ea + eb - 300);
    endfunction

    function automatic logic [31:0] single_add(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] x;
        logic [31:0] y;
        logic [79:0] mx;
        logic [79:0] my;
        logic [79:0] mag;
        int          ex;
        int          ey;
        int          d;
        bit          s;
        if (is_nan(a) || is_nan(b) || (is_inf(a) && is_inf(b) && a[31] != b[31])) begin
            return QNAN;
        end
        if (is_inf(a)) return a;
        if (is_inf(b)) return b;
        if (a[30:23] >= b[30:23]) begin
            x = a;
            y = b;
        end else begin
            x = b;
            y = a;
        end
        ex = (x[30:23] == '0) ? 1 : int'(x[30:23]);
        ey = (y[30:23] == '0) ? 1 : int'(y[30:23]);
        mx = {56'b0, x[30:23] != '0, x[22:0]};
        my = {56'b0, y[30:23] != '0, y[22:0]};
        d  = ex - ey;
        if (d > 50) begin
            my = (my != '0) ? 80'd1 : 80'd0;
            d  = 50;
        end
        mx = mx << d;
        if (x[31] == y[31]) begin
            mag = mx + my;
            s   = x[31];
        end else if (mx > my) begin
            mag = mx - my;
            s   = x[31];
        end else begin
            mag = my - mx;
            s   = y[31];
        end
        if (mag == '0) return {a[31] & b[31], 31'b0};
        return round_single(s, mag, ex - 150 - d);
    endfunction

    function automatic logic [31:0] reduced_lanes();
        logic [31:0] s4 [4];
        for (int j = 0; j < 4; j++) begin
            s4[j] = single_add(single_add(lane_acc[j], lane_acc[j+4]),
                               single_add(lane_acc[j+8], lane_acc[j+12]));
        end
        return single_add(single_add(s4[0], s4[2]), single_add(s4[1], s4[3]));
    endfunction

    function automatic void clear_row_sums();
        col_pos  = '0;
        tail_acc = '0;
        for (int i = 0; i < 16; i++) lane_acc[i] = '0;
    endfunction

    // Advances the row state by one column; returns 1 when the row closes.
    function automatic bit accumulate_column(input logic [15:0] w, input logic [31:0] a,
                                             input logic [15:0] r, output t_row_result res);
        int          cnt;
        int          full;
        int          p;
        logic [31:0] prod;
        logic [31:0] sum;
        cnt  = (cols_per_row == '0) ? 1 : int'(cols_per_row);
        full = cnt & ~15;
        p    = int'(col_pos);
        prod = single_mul(widen_half(w), a);
        if (p < full) begin
            lane_acc[p & 15] = single_add(lane_acc[p & 15], prod);
        end else begin
            if (p == full) tail_acc = reduced_lanes();
            tail_acc = single_add(tail_acc, prod);
        end
        p++;
        if (p < cnt) begin
            col_pos = 16'(p);
            return 1'b0;
        end
        sum = (full == cnt) ? reduced_lanes() : tail_acc;
        res.sum = is_nan(sum) ? QNAN : sum;
        res.row = r;
        clear_row_sums();
        return 1'b1;
    endfunction

    task automatic send_column(input logic [15:0] w, input logic [31:0] a,
                               input logic [15:0] r, input bit known, input logic [31:0] sum);
        t_row_result res;
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {r, a, w};
        do @(posedge i_clk); while (!o_s_tready);
        if (accumulate_column(w, a, r, res)) begin
            if (known) res.sum = sum;
            row_sums_due.push_back(res);
        end
        if ($urandom_range(99) < src_idle_pct) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    task automatic write_column_count(input logic [15:0] value);
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (row_sums_due.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid  <= 1'b0;
        cols_per_row = value;
        clear_row_sums();
    endtask

    function automatic logic [15:0] rand_weight();
        if ($urandom_range(3) == 0) return 16'($urandom);
        return {1'($urandom), 5'($urandom_range(5, 25)), 10'($urandom)};
    endfunction

    function automatic logic [31:0] rand_activation();
        case ($urandom_range(7))
            0: return $urandom;
            1: return {1'($urandom), 8'($urandom_range(0, 1) * 8'hFF), 23'($urandom)};
            default: return {1'($urandom), 8'($urandom_range(100, 150)), 23'($urandom)};
        endcase
    endfunction

    task automatic send_rows(input int rows, input int extra);
        int cnt;
        cnt = (cols_per_row == '0) ? 1 : int'(cols_per_row);
        for (int i = 0; i < rows * cnt + extra; i++) begin
            send_column(rand_weight(), rand_activation(), 16'($urandom), 1'b0, '0);
        end
    endtask

    always @(posedge i_clk) begin
        t_row_result exp_r;
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) begin
                if (row_sums_due.size() == 0) begin
                    $display("%0t: unexpected row sum %h", $time, o_m_tdata);
                    fail_cnt++;
                end else begin
                    exp_r = row_sums_due.pop_front();
                    if (o_m_tdata[31:0] !== exp_r.sum) begin
                        $display("%0t: row_sum expected %h actual %h",
                                 $time, exp_r.sum, o_m_tdata[31:0]);
                        fail_cnt++;
                    end
                    if (o_m_tdata[47:32] !== exp_r.row) begin
                        $display("%0t: out_row expected %h actual %h",
                                 $time, exp_r.row, o_m_tdata[47:32]);
                        fail_cnt++;
                    end
                end
            end
            if (hold_start && !hold_taken) begin
                hold_taken = 1'b1;
                hold_cnt   = 300;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= ($urandom_range(99) >= snk_idle_pct);
            end
        end
    end

    t_dir_row dir_tab [14];
    int       cfg_list [10];

    initial begin
        dir_tab = '{
            '{16'h3C00, 32'h4000_0000, 16'h0000, 1'b1, 32'h4000_0000},
            '{16'h0001, 32'h3F80_0000, 16'hFFFF, 1'b1, 32'h3380_0000},
            '{16'hFBFF, 32'h3F80_0000, 16'h1234, 1'b1, 32'hC77F_E000},
            '{16'h7C00, 32'h0000_0000, 16'h0001, 1'b1, QNAN},
            '{16'h7C00, 32'h3F80_0000, 16'h0002, 1'b1, 32'h7F80_0000},
            '{16'hFC00, 32'h3F80_0000, 16'h0003, 1'b1, 32'hFF80_0000},
            '{16'h7E01, 32'h3F80_0000, 16'h0004, 1'b1, QNAN},
            '{16'h3C00, 32'hFFFF_FFFF, 16'h0005, 1'b1, QNAN},
            '{16'h0000, 32'h8000_0000, 16'h0006, 1'b1, 32'h0000_0000},
            '{16'h03FF, 32'h7F7F_FFFF, 16'h0007, 1'b0, '0},
            '{16'h7BFF, 32'h7F7F_FFFF, 16'h0008, 1'b0, '0},
            '{16'hFFFF, 32'h0000_0001, 16'h0009, 1'b0, '0},
            '{16'h8001, 32'h0080_0000, 16'hAAAA, 1'b0, '0},
            '{16'h5555, 32'hAAAA_AAAA, 16'h5555, 1'b0, '0}
        };
        cfg_list = '{0, 3, 15, 17, 31, 32, 33, 100, 2, 16};
        fail_cnt     = 0;
        src_idle_pct = 25;
        snk_idle_pct = 75;
        hold_start   = 1'b0;
        hold_taken   = 1'b0;
        hold_cnt     = 0;
        i_rst_n      = 1'b0;
        i_s_tvalid   = 1'b0;
        i_s_tdata    = '0;
        i_m_tready   = 1'b0;
        i_cfg_valid  = 1'b0;
        i_cfg_data   = '0;
        cols_per_row = 16'd16;
        clear_row_sums();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_rows(4, 0);
        write_column_count(16'd1);
        foreach (dir_tab[i]) begin
            send_column(dir_tab[i].w, dir_tab[i].a, dir_tab[i].r,
                        dir_tab[i].known, dir_tab[i].sum);
        end

        foreach (cfg_list[i]) begin
            if (i == 4) begin
                src_idle_pct = 75;
                snk_idle_pct = 25;
            end else if (i == 7) begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end
            write_column_count(16'(cfg_list[i]));
            if (i == 5) hold_start <= 1'b1;
            send_rows((cfg_list[i] == 0) ? 200 : (200 + cfg_list[i] - 1) / cfg_list[i], 0);
            if (i == 3) send_rows(0, 5);
        end

        write_column_count(16'hFFFF);
        send_rows(0, 40);
        write_column_count(16'd1);
        send_rows(40, 0);

        i_s_tvalid <= 1'b0;
        while (row_sums_due.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
        if (fail_cnt == 0) begin
            $display("PASS half_weight_row_dot_product_core");
        end else begin
            $display("FAIL half_weight_row_dot_product_core");
        end
        $finish;
    end

endmodule
